FILE: hdl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared definitions of the first-fit block allocator
// Opcodes, status codes, the sequencer state type and default sizes.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // default pool size in cells
    localparam int POOL_CELLS_DEF = 256;

    // fixed field widths
    localparam int OPCODE_W = 2;
    localparam int SIZE_W   = 9;
    localparam int START_W  = 8;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 8;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOCATE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO     = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        S_WIPE,   // map clearing pass after reset
        S_IDLE,   // waiting for a command
        S_SCAN,   // first-fit search, one cell per cycle
        S_WRITE   // marking or freeing a run, one cell per cycle
    } t_state;

endpackage

FILE: hdl/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator: contiguous first-fit allocator over a bitmap
//
// A command beat is taken on a rising edge with start high and busy low:
// i_opcode (allocate, release, clear-and-release), i_block_size and
// i_block_start. Each command gives exactly one result, shown for one
// cycle with o_strobe high: o_status and o_granted_start. The receiver
// cannot hold results off; busy is low again when the result is out.
//
// The occupancy map is a 1-bit RAM of POOL_CELLS entries. After reset a
// clearing pass writes every cell free, one cell per cycle, and busy
// stays high until it ends, so no command is taken before then.
//
// Zero-size, oversize, unused-opcode and empty release commands are
// answered straight from decode. A release frees the clipped cell count.
// An allocate scans from cell 0 until a free run of its size ends, then
// marks that run; a failed search reads all POOL_CELLS cells. The single RAM
// port pair sets the pace: the scan reads one cell per cycle and marking
// writes one cell per cycle. One command is in flight at a time.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int POOL_CELLS = POOL_CELLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [SIZE_W-1:0]   i_block_size,
    input  logic [START_W-1:0]  i_block_start,
    output logic                o_strobe,
    output logic [STATUS_W-1:0] o_status,
    output logic [GRANT_W-1:0]  o_granted_start
);

    // address, count and compare widths
    localparam int AW = $clog2(POOL_CELLS);
    localparam int CW = $clog2(POOL_CELLS + 1);
    localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int GW = (AW > GRANT_W) ? AW : GRANT_W;

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_wr_addr, n_wr_addr;
    logic                 r_wr_val, n_wr_val;
    logic [CW-1:0]        r_rd_addr, n_rd_addr;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_eval_idx, n_eval_idx;
    logic [CW-1:0]        r_run, n_run;
    logic [CW-1:0]        r_size, n_size;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [GRANT_W-1:0]   r_res_start, n_res_start;
    logic                 r_strobe, n_strobe;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [GRANT_W-1:0]   r_granted, n_granted;

    // RAM ports
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic                 w_wdata;
    logic                 w_rdata;

    // command decode
    logic                 w_accept;
    logic [LW-1:0]        w_size_ext;
    logic [LW-1:0]        w_start_ext;
    logic [LW-1:0]        w_pool;
    logic [LW-1:0]        w_remain;
    logic [LW-1:0]        w_free_cnt;
    logic                 w_alloc_zero;
    logic                 w_alloc_big;
    logic                 w_free_none;

    // scan evaluation
    logic [CW-1:0]        w_run_inc;
    logic                 w_found;
    logic                 w_last_cell;
    logic                 w_issue;
    logic [CW-1:0]        w_first_full;
    logic [GW-1:0]        w_first_ext;
    logic                 w_wr_last;

    assign w_accept     = start && !busy;
    assign w_size_ext   = LW'(i_block_size);
    assign w_start_ext  = LW'(i_block_start);
    assign w_pool       = LW'(POOL_CELLS);
    assign w_remain     = w_pool - w_start_ext;
    assign w_free_cnt   = (w_size_ext < w_remain) ? w_size_ext : w_remain;
    assign w_alloc_zero = (i_block_size == '0);
    assign w_alloc_big  = (w_size_ext > w_pool);
    assign w_free_none  = (i_block_size == '0) || (w_start_ext >= w_pool);

    // scan: cell r_eval_idx is on the RAM read data when r_pend is set
    assign w_run_inc    = r_run + CW'(1);
    assign w_found      = r_pend && !w_rdata && (w_run_inc == r_size);
    assign w_last_cell  = r_pend && (r_eval_idx == AW'(POOL_CELLS - 1));
    assign w_issue      = (r_rd_addr < CW'(POOL_CELLS));
    assign w_first_full = CW'(r_eval_idx) + CW'(1) - r_size;
    assign w_first_ext  = GW'(w_first_full[AW-1:0]);
    assign w_wr_last    = (r_cnt == CW'(1));

    // occupancy map
    ffba_ram #(
        .WIDTH (1),
        .DEPTH (POOL_CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_we    = (r_state == S_WIPE) || (r_state == S_WRITE);
    assign w_waddr = r_wr_addr;
    assign w_wdata = (r_state == S_WRITE) ? r_wr_val : 1'b0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WIPE: begin
                if (w_wr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_ALLOCATE) begin
                        if (!w_alloc_zero && !w_alloc_big) n_state = S_SCAN;
                    end else if ((i_opcode == OP_RELEASE) || (i_opcode == OP_CLEAR)) begin
                        if (!w_free_none) n_state = S_WRITE;
                    end
                end
            end
            S_SCAN: begin
                if (w_found) n_state = S_WRITE;
                else if (w_last_cell) n_state = S_IDLE;
            end
            S_WRITE: begin
                if (w_wr_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result updates
    always_comb begin
        n_cnt        = r_cnt;
        n_wr_addr    = r_wr_addr;
        n_wr_val     = r_wr_val;
        n_rd_addr    = r_rd_addr;
        n_pend       = 1'b0;
        n_eval_idx   = r_eval_idx;
        n_run        = r_run;
        n_size       = r_size;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_strobe     = 1'b0;
        n_status     = r_status;
        n_granted    = r_granted;
        unique case (r_state)
            // clearing pass
            S_WIPE: begin
                n_wr_addr = r_wr_addr + AW'(1);
                n_cnt     = r_cnt - CW'(1);
            end
            // command decode and immediate answers
            S_IDLE: begin
                if (w_accept) begin
                    n_status  = STAT_OK;
                    n_granted = '0;
                    priority if (i_opcode == OP_ALLOCATE) begin
                        priority if (w_alloc_zero) begin
                            n_strobe = 1'b1;
                            n_status = STAT_ZERO;
                        end else if (w_alloc_big) begin
                            n_strobe = 1'b1;
                            n_status = STAT_TOO_BIG;
                        end else begin
                            n_size    = CW'(i_block_size);
                            n_rd_addr = '0;
                            n_run     = '0;
                        end
                    end else if ((i_opcode == OP_RELEASE) || (i_opcode == OP_CLEAR)) begin
                        if (w_free_none) begin
                            n_strobe = 1'b1;
                        end else begin
                            n_wr_addr    = AW'(i_block_start);
                            n_cnt        = CW'(w_free_cnt);
                            n_wr_val     = 1'b0;
                            n_res_status = STAT_OK;
                            n_res_start  = '0;
                        end
                    end else begin
                        n_strobe = 1'b1;
                    end
                end
            end
            // issue one read and evaluate one cell per cycle
            S_SCAN: begin
                if (w_issue) begin
                    n_rd_addr  = r_rd_addr + CW'(1);
                    n_pend     = 1'b1;
                    n_eval_idx = r_rd_addr[AW-1:0];
                end
                if (r_pend) begin
                    n_run = w_rdata ? '0 : w_run_inc;
                end
                if (w_found) begin
                    n_pend       = 1'b0;
                    n_wr_addr    = w_first_full[AW-1:0];
                    n_cnt        = r_size;
                    n_wr_val     = 1'b1;
                    n_res_status = STAT_OK;
                    n_res_start  = w_first_ext[GRANT_W-1:0];
                end else if (w_last_cell) begin
                    n_pend    = 1'b0;
                    n_strobe  = 1'b1;
                    n_status  = STAT_NO_SPACE;
                    n_granted = '0;
                end
            end
            // mark or free the run, answer after the last cell
            S_WRITE: begin
                n_wr_addr = r_wr_addr + AW'(1);
                n_cnt     = r_cnt - CW'(1);
                if (w_wr_last) begin
                    n_strobe  = 1'b1;
                    n_status  = r_res_status;
                    n_granted = r_res_start;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_WIPE;
            r_cnt     <= CW'(POOL_CELLS);
            r_wr_addr <= '0;
            r_pend    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_wr_addr <= n_wr_addr;
            r_pend    <= n_pend;
            r_strobe  <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_val     <= n_wr_val;
        r_rd_addr    <= n_rd_addr;
        r_eval_idx   <= n_eval_idx;
        r_run        <= n_run;
        r_size       <= n_size;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_status     <= n_status;
        r_granted    <= n_granted;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_granted_start = r_granted;

    // checks
    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || r_strobe))
        else $error("accepted command neither busy nor answered");

    a_no_strobe_in_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIPE) |-> !r_strobe)
        else $error("result strobe during clearing pass");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status != STAT_OK)) |-> (r_granted == '0))
        else $error("granted start nonzero on failed allocate");

    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) || (r_state == S_WIPE)) |-> (r_cnt != '0))
        else $error("write sweep with zero remaining count");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_size))
        else $error("free run reached size without a grant");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of the first-fit block allocator
// A directed table covers the edge cases of the occupancy map: zero and
// oversize requests, a full pool, release clipping at the pool end and the
// unused opcode. A random phase follows. Its allocate and free beats mostly
// come in matched pairs, so the map fills, fragments and drains. Every
// result is checked against its typed table entry or a bench bitmap predictor.
// ----------------------------------------------------------------------------
module testbench;
    import ffba_pkg::*;

    localparam int POOL       = POOL_CELLS_DEF;
    localparam int N_RANDOM   = 1800;
    localparam int N_DIRECTED = 25;
    localparam int WATCHDOG   = 4000;
    localparam int MAX_REPORT = 10;

    // opcode with no function; the block answers it with a plain ok
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [SIZE_W-1:0]   size;
        logic [START_W-1:0]  first;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  grant;
    } t_cmd_row;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  grant;
    } t_alloc_result;

    typedef struct {
        int first;
        int size;
    } t_live_block;

    localparam t_cmd_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_ALLOCATE, 9'd0,   8'd0,   1'b1, STAT_ZERO,     8'd0},
        '{OP_ALLOCATE, 9'd257, 8'd0,   1'b1, STAT_TOO_BIG,  8'd0},
        '{OP_ALLOCATE, 9'd511, 8'd255, 1'b1, STAT_TOO_BIG,  8'd0},
        '{OP_ALLOCATE, 9'd1,   8'd0,   1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd3,   8'd0,   1'b1, STAT_OK,       8'd1},
        '{OP_RELEASE,  9'd1,   8'd0,   1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd2,   8'd0,   1'b0, STAT_OK,       8'd0},
        '{OP_CLEAR,    9'd3,   8'd1,   1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd256, 8'd0,   1'b1, STAT_NO_SPACE, 8'd0},
        '{OP_RELEASE,  9'd256, 8'd0,   1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd256, 8'd0,   1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd1,   8'd0,   1'b1, STAT_NO_SPACE, 8'd0},
        '{OP_RELEASE,  9'd256, 8'd255, 1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd1,   8'd0,   1'b1, STAT_OK,       8'd255},
        '{OP_UNUSED,   9'd511, 8'd255, 1'b1, STAT_OK,       8'd0},
        '{OP_RELEASE,  9'd0,   8'd200, 1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd1,   8'd0,   1'b1, STAT_NO_SPACE, 8'd0},
        '{OP_CLEAR,    9'd511, 8'd0,   1'b1, STAT_OK,       8'd0},
        '{OP_RELEASE,  9'd1,   8'd255, 1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd128, 8'd0,   1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd128, 8'd0,   1'b1, STAT_OK,       8'd128},
        '{OP_RELEASE,  9'd64,  8'd64,  1'b1, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd65,  8'd0,   1'b0, STAT_OK,       8'd0},
        '{OP_ALLOCATE, 9'd64,  8'd0,   1'b0, STAT_OK,       8'd0},
        '{OP_RELEASE,  9'd256, 8'd0,   1'b1, STAT_OK,       8'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OPCODE_W-1:0] i_opcode;
    logic [SIZE_W-1:0]   i_block_size;
    logic [START_W-1:0]  i_block_start;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [GRANT_W-1:0]  o_granted_start;

    // predictor state: occupancy map and the runs handed out so far
    logic [POOL-1:0] pool_map;
    t_live_block     live_blocks [$];
    t_alloc_result   pending_results [$];

    int error_count = 0;
    int n_results   = 0;
    int n_cmds      = 0;
    int n_grants    = 0;
    int n_no_space  = 0;
    int n_rejects   = 0;
    int n_frees     = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    first_fit_block_allocator #(
        .POOL_CELLS(POOL)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_block_size   (i_block_size),
        .i_block_start  (i_block_start),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_granted_start(o_granted_start)
    );

    // 125 MHz clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // first-fit search and release on the bench copy of the map
    function automatic t_alloc_result predict_result(
        input logic [OPCODE_W-1:0] op,
        input logic [SIZE_W-1:0]   size,
        input logic [START_W-1:0]  first
    );
        t_alloc_result res;
        int run;
        int base;
        int stop;
        bit found;
        res    = '{STAT_OK, '0};
        run    = 0;
        found  = 1'b0;
        if (op == OP_ALLOCATE) begin
            if (size == 0) begin
                res.status = STAT_ZERO;
            end else if (int'(size) > POOL) begin
                res.status = STAT_TOO_BIG;
            end else begin
                for (int i = 0; i < POOL; i++) begin
                    if (!found) begin
                        run = pool_map[i] ? 0 : run + 1;
                        if (run == int'(size)) begin
                            base = i + 1 - run;
                            for (int j = base; j <= i; j++) pool_map[j] = 1'b1;
                            res.grant = base[GRANT_W-1:0];
                            found = 1'b1;
                        end
                    end
                end
                if (!found) res.status = STAT_NO_SPACE;
            end
        end else if (op == OP_RELEASE || op == OP_CLEAR) begin
            // free range clipped at the pool end
            stop = int'(first) + int'(size);
            if (stop > POOL) stop = POOL;
            for (int i = int'(first); i < stop; i++) pool_map[i] = 1'b0;
        end
        return res;
    endfunction

    // drive one command beat, wait for it to be taken, queue its result
    task automatic send_cmd(
        input logic [OPCODE_W-1:0] op,
        input logic [SIZE_W-1:0]   size,
        input logic [START_W-1:0]  first,
        input logic                typed,
        input t_alloc_result       typed_res
    );
        t_alloc_result res;
        t_live_block   blk;
        start         <= 1'b1;
        i_opcode      <= op;
        i_block_size  <= size;
        i_block_start <= first;
        do @(posedge i_clk); while (busy !== 1'b0);
        res = predict_result(op, size, first);
        pending_results.push_back(typed ? typed_res : res);
        n_cmds++;
        if (op == OP_ALLOCATE) begin
            case (res.status)
                STAT_OK: begin
                    n_grants++;
                    blk.first = int'(res.grant);
                    blk.size  = int'(size);
                    live_blocks.push_back(blk);
                end
                STAT_NO_SPACE: n_no_space++;
                default: n_rejects++;
            endcase
        end else if (op != OP_UNUSED) begin
            n_frees++;
        end
    endtask

    // bursty sender: after a burst drop start for a random gap
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // occasional long back-to-back stretches
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end
    endtask

    // stimulus: reset, directed table, then random traffic
    initial begin
        logic [OPCODE_W-1:0] op;
        logic [SIZE_W-1:0]   size;
        logic [START_W-1:0]  first;
        t_live_block         blk;
        int                  sel;
        int                  idx;
        int                  alloc_weight;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_ALLOCATE;
        i_block_size  = '0;
        i_block_start = '0;
        pool_map      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            send_cmd(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].size,
                     DIRECTED_ROWS[r].first, DIRECTED_ROWS[r].typed,
                     '{DIRECTED_ROWS[r].status, DIRECTED_ROWS[r].grant});
            pace_sender();
        end
        // the table ends with a full release, so nothing is live any more
        live_blocks.delete();

        for (int n = 0; n < N_RANDOM; n++) begin
            // favor allocation until the pool is nearly full
            alloc_weight = ($countones(pool_map) > 224) ? 30 : 55;
            sel   = $urandom_range(0, 99);
            first = START_W'($urandom_range(0, 255));
            if (sel < alloc_weight) begin
                op  = OP_ALLOCATE;
                sel = $urandom_range(0, 99);
                if (sel < 65)      size = SIZE_W'($urandom_range(1, 8));
                else if (sel < 88) size = SIZE_W'($urandom_range(9, 48));
                else if (sel < 96) size = SIZE_W'($urandom_range(49, 256));
                else               size = $urandom_range(0, 1) ? 9'd0
                                              : SIZE_W'($urandom_range(257, 511));
            end else if (sel < 90 && live_blocks.size() > 0) begin
                // free a run handed out earlier
                idx   = $urandom_range(0, live_blocks.size() - 1);
                blk   = live_blocks[idx];
                live_blocks.delete(idx);
                op    = $urandom_range(0, 1) ? OP_RELEASE : OP_CLEAR;
                size  = SIZE_W'(blk.size);
                first = START_W'(blk.first);
            end else begin
                // stray free of arbitrary cells, or the unused opcode
                op   = OPCODE_W'($urandom_range(1, 3));
                size = $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 511))
                                            : SIZE_W'($urandom_range(0, 16));
            end
            send_cmd(op, size, first, 1'b0, '{STAT_OK, '0});
            pace_sender();
        end

        // drain, then watch for stray results for a full scan time
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (POOL + 8) @(posedge i_clk);

        $display("covered %0d commands: %0d grants, %0d no-space, %0d size rejects, %0d frees",
                 n_cmds, n_grants, n_no_space, n_rejects, n_frees);
        $display("%0d results checked, %0d errors", n_results, error_count);
        if (error_count == 0) begin
            $display("first_fit_block_allocator regression: pass");
        end else begin
            $display("first_fit_block_allocator regression: fail");
        end
        $finish;
    end

    // result checker: every strobe beat against the oldest expectation
    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && o_strobe === 1'b1) begin
            n_results++;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORT)
                    $display("result beat %0d with nothing expected: status %0d grant %0d",
                             n_results, o_status, o_granted_start);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status || o_granted_start !== exp_res.grant) begin
                    error_count++;
                    if (error_count <= MAX_REPORT)
                        $display("result beat %0d: status exp %0d got %0d, grant exp %0d got %0d",
                                 n_results, exp_res.status, o_status,
                                 exp_res.grant, o_granted_start);
                end
            end
        end
    end

    // watchdog on cycles with neither a command nor a result beat
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("first_fit_block_allocator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
